FILE: hdl/gf2_matrix_times_wide_vector_unit_defines.svh
// Assertion macros used by the RTL of the GF(2) matrix times wide vector unit.
// Defining ASSERT_OFF leaves every assertion out of the build.
`ifndef GF2_MATRIX_TIMES_WIDE_VECTOR_UNIT_DEFINES_SVH
`define GF2_MATRIX_TIMES_WIDE_VECTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define GMV_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GMV_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMV_ASSERT_RST(lbl, clk, rst, prop, msg)
`define GMV_ASSERT(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/gmv_pkg.sv
// Package for the GF(2) matrix times wide vector unit: sizes, codes and types.
// Used by every module of the unit but gmv_ram; depends on nothing.
`timescale 1ns / 1ps
package gmv_pkg;

   localparam int MAX_COLUMNS  = 4096;
   localparam int NUM_BANKS    = 8;
   localparam int WORDS        = 4;
   localparam int WORD_W       = 64;
   localparam int BANK_DEPTH   = MAX_COLUMNS / NUM_BANKS;
   localparam int BANK_AW      = $clog2(BANK_DEPTH);
   localparam int BANK_SEL_W   = $clog2(NUM_BANKS);
   localparam int ELEM_W       = 12;
   localparam int COUNT_W      = 13;
   localparam int ROW_W        = 16;
   localparam int MODE_W       = 2;
   localparam int WSEL_W       = 2;
   localparam int BYTE_W       = 8;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_DATA_W   = 272;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [0:0] FUNC_LOAD   = 1'b0;
   localparam logic [0:0] FUNC_MATRIX = 1'b1;

   localparam logic [MODE_W-1:0] MODE_128 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_192 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_256 = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 2'd2;

   typedef logic [WORD_W-1:0]            word_type;
   typedef word_type [WORDS-1:0]         element_type;
   typedef element_type [NUM_BANKS-1:0]  bank_row_type;

   typedef struct packed {
      logic                 valid;
      logic [NUM_BANKS-1:0] bit_mask;
      logic [WORDS-1:0]     word_en;
      logic                 row_end;
      logic [ROW_W-1:0]     row_index;
      logic                 last_row;
   } item_type;

endpackage

FILE: hdl/gmv_ram.sv
// Simple dual-port synchronous RAM with registered read.
// Generic; depends on nothing.
`timescale 1ns / 1ps
module gmv_ram #(
   parameter int DATA_W = 64,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/gmv_store.sv
// Vector store: eight column banks of four word memories each.
// Depends on gmv_pkg and gmv_ram.
`timescale 1ns / 1ps
module gmv_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [gmv_pkg::ELEM_W-1:0]    wr_elem,
   input  logic [gmv_pkg::WSEL_W-1:0]    wr_word,
   input  gmv_pkg::word_type             wr_data,
   input  logic                          rd_en,
   input  logic [gmv_pkg::BANK_AW-1:0]   rd_row,
   output gmv_pkg::bank_row_type         rd_data
);
   import gmv_pkg::*;

   logic [BANK_AW-1:0] wr_row;

   assign wr_row = wr_elem[BANK_SEL_W +: BANK_AW];

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      for (genvar w = 0; w < WORDS; w++) begin : g_word
         logic sel;
         assign sel = wr_en && (wr_elem[BANK_SEL_W-1:0] == BANK_SEL_W'(b))
                      && (wr_word == WSEL_W'(w));
         gmv_ram #(
            .DATA_W (WORD_W),
            .ADDR_W (BANK_AW)
         ) u_ram (
            .clock   (clock),
            .wr_en   (sel),
            .wr_addr (wr_row),
            .wr_data (wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_row),
            .rd_data (rd_data[b][w])
         );
      end
   end

endmodule

FILE: hdl/gmv_accum.sv
// Row accumulator stage and result register of the GF(2) matrix vector unit.
// Depends on gmv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gf2_matrix_times_wide_vector_unit_defines.svh"
module gmv_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  gmv_pkg::item_type               item_in,
   input  gmv_pkg::bank_row_type           bank_data,
   output logic                            stall,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // word0, word1, word2, word3, row_index
   output logic [gmv_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import gmv_pkg::*;

   item_type    s1_ff, s1_in;
   element_type acc_ff, acc_in, acc_sum, sel_sum, out_words_ff, out_words_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic        out_last_ff, out_last_in;
   logic        out_valid_ff, out_valid_in;
   logic        advance;

   assign stall   = s1_ff.valid && s1_ff.row_end && out_valid_ff && !rsp_tready;
   assign advance = s1_ff.valid && !stall;

   always_comb begin
      sel_sum = '0;
      for (int k = 0; k < NUM_BANKS; k++) begin
         if (s1_ff.bit_mask[k]) begin
            sel_sum = sel_sum ^ bank_data[k];
         end
      end
      for (int w = 0; w < WORDS; w++) begin
         acc_sum[w] = s1_ff.word_en[w] ? (acc_ff[w] ^ sel_sum[w]) : acc_ff[w];
      end
   end

   always_comb begin
      s1_in        = stall ? s1_ff : item_in;
      acc_in       = acc_ff;
      out_words_in = out_words_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance) begin
         acc_in = s1_ff.row_end ? '0 : acc_sum;
         if (s1_ff.row_end) begin
            for (int w = 0; w < WORDS; w++) begin
               out_words_in[w] = s1_ff.word_en[w] ? acc_sum[w] : '0;
            end
            out_row_in   = s1_ff.row_index;
            out_last_in  = s1_ff.last_row;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff.bit_mask  <= s1_in.bit_mask;
      s1_ff.word_en   <= s1_in.word_en;
      s1_ff.row_end   <= s1_in.row_end;
      s1_ff.row_index <= s1_in.row_index;
      s1_ff.last_row  <= s1_in.last_row;
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid  <= s1_in.valid;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_words_ff    <= out_words_in;
      out_row_ff      <= out_row_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_row_ff, out_words_ff};
   assign rsp_tlast  = out_last_ff;

   `GMV_ASSERT_RST(a_no_push_when_stalled, clock, reset,
      stall |-> !item_in.valid, "new matrix word pushed while the accumulator stalls")
   `GMV_ASSERT_RST(a_acc_cleared_after_row, clock, reset,
      (advance && s1_ff.row_end) |=> (acc_ff == '0), "accumulator not cleared after a row")
   `GMV_ASSERT_RST(a_row_result_held, clock, reset,
      (advance && s1_ff.row_end) |=> out_valid_ff, "row result not presented")
   `GMV_ASSERT(a_reset_clears_output, clock,
      reset |=> !out_valid_ff, "result valid after reset")

endmodule

FILE: hdl/gf2_matrix_times_wide_vector_unit.sv
// GF(2) matrix times wide vector unit: a row's last matrix word passes the stage register
// and the result register before its row result shows on rsp; one word accepted per cycle,
// held off only while a finished row waits in the result register and another row ends.
// The store reads all eight columns of a matrix byte at once from eight column banks.
// Synchronous active-high reset restores default configuration, clears positions and
// accumulator; the vector store is not cleared and holds nothing defined until loaded.
`timescale 1ns / 1ps
module gf2_matrix_times_wide_vector_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // element_index, word_select, word_data, matrix_byte, zero padding
   input  logic [gmv_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_word0, result_word1, result_word2, result_word3, row_index
   output logic [gmv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [gmv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gmv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gmv_pkg::*;

   logic [MODE_W-1:0]  element_mode_ff, element_mode_in;
   logic [COUNT_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   logic [COUNT_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]   row_pos_ff, row_pos_in;

   logic [ELEM_W-1:0]  elem;
   logic [WSEL_W-1:0]  wsel;
   word_type           wdata;
   logic [BYTE_W-1:0]  mbyte;
   logic               accept, load, matrix, stall;
   logic [COUNT_W-1:0] cols_eff, col_next;
   logic [ROW_W-1:0]   rows_eff;
   item_type           item;
   bank_row_type       bank_data;

   assign elem  = req_tdata[ELEM_W-1:0];
   assign wsel  = req_tdata[ELEM_W +: WSEL_W];
   assign wdata = req_tdata[ELEM_W + WSEL_W +: WORD_W];
   assign mbyte = req_tdata[ELEM_W + WSEL_W + WORD_W +: BYTE_W];

   assign req_tready = !stall;
   assign accept     = req_tvalid && req_tready;
   assign load       = accept && (req_tuser == FUNC_LOAD);
   assign matrix     = accept && (req_tuser == FUNC_MATRIX);

   always_comb begin
      element_mode_in = element_mode_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ELEMENT_MODE: element_mode_in = csr_wdata[MODE_W-1:0];
            CSR_COLUMN_COUNT: column_count_in = csr_wdata[COUNT_W-1:0];
            CSR_ROW_COUNT:    row_count_in    = csr_wdata[ROW_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      if (column_count_ff == '0) begin
         cols_eff = COUNT_W'(1);
      end else if (column_count_ff > COUNT_W'(MAX_COLUMNS)) begin
         cols_eff = COUNT_W'(MAX_COLUMNS);
      end else begin
         cols_eff = column_count_ff;
      end
      rows_eff = (row_count_ff == '0) ? ROW_W'(1) : row_count_ff;
      col_next = col_pos_ff + COUNT_W'(NUM_BANKS);

      item.valid = matrix;
      for (int k = 0; k < NUM_BANKS; k++) begin
         item.bit_mask[k] = mbyte[k] && ((col_pos_ff + COUNT_W'(k)) < cols_eff);
      end
      unique case (element_mode_ff)
         MODE_128: item.word_en = 4'b0011;
         MODE_192: item.word_en = 4'b0111;
         default:  item.word_en = 4'b1111;
      endcase
      item.row_end   = (col_next >= cols_eff) || (col_next < COUNT_W'(NUM_BANKS));
      item.row_index = row_pos_ff;
      item.last_row  = row_pos_ff >= (rows_eff - ROW_W'(1));

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (matrix) begin
         if (item.row_end) begin
            col_pos_in = '0;
            row_pos_in = item.last_row ? '0 : (row_pos_ff + ROW_W'(1));
         end else begin
            col_pos_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_mode_ff <= MODE_128;
         column_count_ff <= COUNT_W'(MAX_COLUMNS);
         row_count_ff    <= ROW_W'(1);
         col_pos_ff      <= '0;
         row_pos_ff      <= '0;
      end else begin
         element_mode_ff <= element_mode_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         col_pos_ff      <= col_pos_in;
         row_pos_ff      <= row_pos_in;
      end
   end

   gmv_store u_store (
      .clock     (clock),
      .wr_en     (load),
      .wr_elem   (elem),
      .wr_word   (wsel),
      .wr_data   (wdata),
      .rd_en     (matrix),
      .rd_row    (col_pos_ff[BANK_SEL_W +: BANK_AW]),
      .rd_data   (bank_data)
   );

   gmv_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .item_in    (item),
      .bank_data  (bank_data),
      .stall      (stall),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/gf2_matrix_times_wide_vector_unit_tb.sv
// Self-checking testbench for the GF(2) matrix times wide vector unit: a directed table,
// a full-width row, then random load and matrix phases, checked by a built-in predictor.
// Depends on gmv_pkg and the gf2_matrix_times_wide_vector_unit RTL only.
`timescale 1ns / 1ps
module gf2_matrix_times_wide_vector_unit_tb;
   import gmv_pkg::*;

   localparam int          IDLE_LIMIT  = 3000;
   localparam int          ITEM_TARGET = 1450;
   localparam logic [63:0] ONES        = {64{1'b1}};
   localparam logic [63:0] ALT_A       = {32{2'b10}};
   localparam logic [63:0] ALT_5       = {32{2'b01}};
   localparam logic [63:0] TOP_BIT     = {1'b1, 63'd0};

   typedef struct packed {
      logic [WORDS-1:0][WORD_W-1:0] words;
      logic [ROW_W-1:0]             row_index;
      logic                         last_row;
   } row_product_type;

   typedef struct {
      logic [0:0]        func;
      logic [ELEM_W-1:0] elem;
      logic [WSEL_W-1:0] wsel;
      logic [63:0]       data;
      logic [BYTE_W-1:0] mbyte;
      bit                typed;
      logic [63:0]       w0, w1, w2, w3;
      logic [ROW_W-1:0]  row;
      logic              last;
   } directed_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow of the unit: vector store, accumulator, positions and registers.
   logic [63:0]      vec_words [0:MAX_COLUMNS*WORDS-1];
   bit               vec_loaded [0:MAX_COLUMNS*WORDS-1];
   logic [63:0]      acc_words [0:WORDS-1];
   logic [COUNT_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   logic [MODE_W-1:0] cfg_mode;
   logic [COUNT_W-1:0] cfg_cols;
   logic [ROW_W-1:0] cfg_rows;

   row_product_type pending_row_products [$];
   int unsigned  items_sent;
   int unsigned  rows_done;
   int unsigned  mismatches;
   int unsigned  idle_cycles;
   bit           sender_quiet;
   bit           hold_req;
   bit           hold_active;

   directed_word_type directed_words [14] = '{
      '{FUNC_LOAD,   12'd0,    2'd0, ONES,    8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd0,    2'd1, 64'd0,   8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd0,    2'd2, ALT_A,   8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd0,    2'd3, ALT_5,   8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd7,    2'd0, 64'd1,   8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd7,    2'd1, 64'd2,   8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd7,    2'd2, 64'd3,   8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd7,    2'd3, TOP_BIT, 8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_LOAD,   12'd4095, 2'd3, ONES,    8'h00, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_MATRIX, 12'd0,    2'd0, 64'd0,   8'h00, 1'b1, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_MATRIX, 12'd4095, 2'd3, ONES,    8'h01, 1'b1,
        ONES, 64'd0, ALT_A, ALT_5, 16'd1, 1'b1},
      '{FUNC_MATRIX, 12'd0,    2'd0, 64'd0,   8'h81, 1'b0, 0, 0, 0, 0, 16'd0, 1'b0},
      '{FUNC_MATRIX, 12'd0,    2'd0, 64'd0,   8'h80, 1'b1,
        64'd1, 64'd2, 64'd3, TOP_BIT, 16'd1, 1'b1},
      '{FUNC_MATRIX, 12'd0,    2'd0, 64'd0,   8'h80, 1'b1,
        64'd1, 64'd2, 64'd3, TOP_BIT, 16'd0, 1'b0}
   };

   gf2_matrix_times_wide_vector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int active_word_count();
      case (cfg_mode)
         MODE_128: return 2;
         MODE_192: return 3;
         default: return 4;
      endcase
   endfunction

   function automatic int effective_columns();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(cfg_cols);
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [7:0] random_matrix_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Clears every bit that would select a column whose active words are not all loaded.
   function automatic logic [7:0] loaded_columns_only(input logic [7:0] raw);
      logic [7:0] keep;
      int         col;
      keep = raw;
      for (int k = 0; k < 8; k++) begin
         col = int'(col_pos) + k;
         if (col < effective_columns()) begin
            for (int w = 0; w < active_word_count(); w++) begin
               if (!vec_loaded[col*WORDS + w]) keep[k] = 1'b0;
            end
         end
      end
      return keep;
   endfunction

   function automatic void advance_product(input logic [0:0] func,
                                           input logic [ELEM_W-1:0] elem,
                                           input logic [WSEL_W-1:0] wsel,
                                           input logic [63:0] data,
                                           input logic [7:0] mbyte,
                                           output bit produced,
                                           output row_product_type prod);
      int  cols;
      int  nw;
      int  col;
      int  rc;
      bit  last;
      produced = 1'b0;
      prod = '0;
      if (func == FUNC_LOAD) begin
         vec_words[{elem, wsel}] = data;
         vec_loaded[{elem, wsel}] = 1'b1;
         return;
      end
      cols = effective_columns();
      nw = active_word_count();
      for (int k = 0; k < 8; k++) begin
         col = int'(col_pos) + k;
         if (mbyte[k] && col < cols) begin
            for (int w = 0; w < nw; w++) acc_words[w] ^= vec_words[col*WORDS + w];
         end
      end
      col_pos = col_pos + COUNT_W'(8);
      if (col_pos < cols && col_pos >= 8) return;
      rc = (cfg_rows == 0) ? 1 : int'(cfg_rows);
      last = int'(row_pos) >= rc - 1;
      for (int w = 0; w < WORDS; w++) prod.words[w] = (w < nw) ? acc_words[w] : 64'd0;
      prod.row_index = row_pos;
      prod.last_row = last;
      produced = 1'b1;
      for (int w = 0; w < WORDS; w++) acc_words[w] = 64'd0;
      col_pos = '0;
      row_pos = last ? '0 : row_pos + ROW_W'(1);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      mismatches++;
   endtask

   task automatic send_word(input logic [0:0] func, input logic [ELEM_W-1:0] elem,
                            input logic [WSEL_W-1:0] wsel, input logic [63:0] data,
                            input logic [7:0] mbyte, input bit typed,
                            input row_product_type typed_row);
      int              gap;
      int              pick;
      bit              produced;
      row_product_type prod;
      pick = $urandom_range(0, 99);
      if (sender_quiet || pick < 70) gap = 0;
      else if (pick < 96) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= func;
      req_tdata <= {2'b00, mbyte, data, wsel, elem};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      advance_product(func, elem, wsel, data, mbyte, produced, prod);
      if (produced) begin
         rows_done++;
         pending_row_products.push_back(typed ? typed_row : prod);
      end
   endtask

   task automatic load_word(input int elem, input int wsel, input logic [63:0] data);
      send_word(FUNC_LOAD, ELEM_W'(elem), WSEL_W'(wsel), data, 8'($urandom), 1'b0, '0);
   endtask

   task automatic matrix_word(input logic [7:0] raw);
      send_word(FUNC_MATRIX, ELEM_W'($urandom), WSEL_W'($urandom), {$urandom, $urandom},
                loaded_columns_only(raw), 1'b0, '0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      case (index)
         CSR_ELEMENT_MODE: cfg_mode = value[MODE_W-1:0];
         CSR_COLUMN_COUNT: cfg_cols = value[COUNT_W-1:0];
         CSR_ROW_COUNT: cfg_rows = value[ROW_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering words and waits for every expected row.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_row_products.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input bit squeeze);
      int mode;
      int cols;
      int rows;
      int ncol;
      int nw;
      int nrows;
      int target;
      settle();
      mode = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
         0: cols = 0;
         1: cols = $urandom_range(40, 96);
         default: cols = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 9))
         0: rows = 0;
         1: rows = 65535;
         default: rows = $urandom_range(1, 5);
      endcase
      if (squeeze) cols = 1;
      write_reg(CSR_ELEMENT_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'(cols));
      write_reg(CSR_ROW_COUNT, CSR_DATA_W'(rows));
      sender_quiet = squeeze || ($urandom_range(0, 4) == 0);
      ncol = effective_columns();
      nw = active_word_count();
      for (int c = 0; c < ncol; c++) begin
         for (int w = 0; w < WORDS; w++) begin
            if ((w < nw && !vec_loaded[c*WORDS + w]) || $urandom_range(0, 5) == 0)
               load_word(c, w, random_word());
         end
      end
      if (squeeze) begin
         settle();
         hold_req = 1'b1;
         wait (hold_active);
      end
      nrows = squeeze ? 60 : $urandom_range(1, 6);
      target = rows_done + nrows;
      while (rows_done < target) begin
         if (!squeeze && $urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0)
               load_word($urandom_range(0, ncol - 1), $urandom_range(0, 3), random_word());
            else
               load_word($urandom_range(0, 4095), $urandom_range(0, 3), random_word());
         end
         matrix_word(random_matrix_byte());
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) matrix_word(random_matrix_byte());
      end
   endtask

   // One row across the full width; the column count is raised past the maximum halfway.
   task automatic run_full_width_row();
      int start;
      settle();
      write_reg(CSR_ELEMENT_MODE, MODE_128);
      write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'(MAX_COLUMNS));
      write_reg(CSR_ROW_COUNT, CSR_DATA_W'(1));
      sender_quiet = 1'b0;
      for (int w = 0; w < 2; w++) begin
         load_word(0, w, random_word());
         load_word(MAX_COLUMNS - 1, w, random_word());
      end
      repeat (14) begin
         start = $urandom_range(1, MAX_COLUMNS - 2);
         load_word(start, 0, random_word());
         load_word(start, 1, random_word());
      end
      repeat (MAX_COLUMNS / 16) matrix_word(8'($urandom));
      settle();
      write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'(8191));
      start = rows_done;
      while (rows_done == start) matrix_word(8'hFF);
   endtask

   always @(posedge clock) begin
      row_product_type got;
      row_product_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.words = rsp_tdata[WORDS*WORD_W-1:0];
         got.row_index = rsp_tdata[RSP_DATA_W-1:WORDS*WORD_W];
         got.last_row = rsp_tlast;
         if (pending_row_products.size() == 0) begin
            report_mismatch("row result with none pending", 64'(got.row_index), 64'd0);
         end else begin
            want = pending_row_products.pop_front();
            for (int w = 0; w < WORDS; w++) begin
               if (got.words[w] !== want.words[w])
                  report_mismatch($sformatf("result_word%0d of row %0d", w, want.row_index),
                                  got.words[w], want.words[w]);
            end
            if (got.row_index !== want.row_index)
               report_mismatch("row_index", 64'(got.row_index), 64'(want.row_index));
            if (got.last_row !== want.last_row)
               report_mismatch($sformatf("last_row of row %0d", want.row_index),
                               64'(got.last_row), 64'(want.last_row));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("gf2_matrix_times_wide_vector_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      forever begin
         if (hold_req) begin
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (120) @(posedge clock);
            hold_active = 1'b0;
            hold_req = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 24)) @(posedge clock);
            end else if (pick < 93) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 50)) @(posedge clock);
            end
         end
      end
   end

   initial begin
      row_product_type typed_row;
      for (int w = 0; w < WORDS; w++) acc_words[w] = 64'd0;
      col_pos = '0;
      row_pos = '0;
      cfg_mode = MODE_128;
      cfg_cols = COUNT_W'(MAX_COLUMNS);
      cfg_rows = ROW_W'(1);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_ELEMENT_MODE, MODE_256);
      write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'(8));
      write_reg(CSR_ROW_COUNT, CSR_DATA_W'(2));
      sender_quiet = 1'b1;
      foreach (directed_words[i]) begin
         typed_row.words = {directed_words[i].w3, directed_words[i].w2,
                            directed_words[i].w1, directed_words[i].w0};
         typed_row.row_index = directed_words[i].row;
         typed_row.last_row = directed_words[i].last;
         send_word(directed_words[i].func, directed_words[i].elem, directed_words[i].wsel,
                   directed_words[i].data, directed_words[i].mbyte, directed_words[i].typed,
                   typed_row);
      end

      run_full_width_row();
      run_phase(1'b1);
      while (items_sent < ITEM_TARGET) run_phase($urandom_range(0, 24) == 0);

      settle();
      repeat (6) @(posedge clock);
      while (pending_row_products.size() != 0) begin
         report_mismatch("row result never arrived",
                         64'(pending_row_products[0].row_index), 64'd0);
         void'(pending_row_products.pop_front());
      end
      if (mismatches == 0) begin
         $display("gf2_matrix_times_wide_vector_unit verification clean");
      end else begin
         $display("gf2_matrix_times_wide_vector_unit verification failed");
      end
      $finish;
   end

endmodule
